[rtl/mctt_pkg.sv]
// ============================================================================
// mctt_pkg: shared types and codes of the tick timer / PWM bank
// Command and result layouts, operation, kind, phase and status codes.
// ============================================================================
package mctt_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int COUNT_BITS_DEF = 32;
    localparam int DUTY_FS_DEF    = 1000;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ALLOC  = 3'd1;
    localparam logic [2:0] MODE_START  = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_DUTY   = 3'd4;
    localparam logic [2:0] MODE_REMOVE = 3'd5;
    localparam logic [2:0] MODE_QUERY  = 3'd6;

    localparam logic [1:0] KIND_ONCE   = 2'd0;
    localparam logic [1:0] KIND_REPEAT = 2'd1;
    localparam logic [1:0] KIND_PWM    = 2'd2;

    localparam logic [1:0] PHASE_STOP   = 2'd0;
    localparam logic [1:0] PHASE_RUN    = 2'd1;
    localparam logic [1:0] PHASE_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_ARG   = 2'd1;
    localparam logic [1:0] STATUS_NO_FREE   = 2'd2;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  channel;
        logic [1:0]  kind;
        logic [31:0] target;
        logic [15:0] duty;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  allocated_index;
        logic [7:0]  event_mask;
        logic [7:0]  pwm_levels;
        logic [31:0] remaining;
        logic [31:0] elapsed;
    } t_result;

    // Side effects reported by the channel update unit.
    typedef struct packed {
        logic wr;
        logic bad_arg;
        logic event_hit;
        logic pwm_wr;
        logic pwm_val;
    } t_step_flags;

endpackage

[rtl/mctt_mem.sv]
// ============================================================================
// mctt_mem: channel entry memory
// One write port and one read port with registered read data.
// ============================================================================
module mctt_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 100,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mctt_duty.sv]
// ============================================================================
// mctt_duty: duty tick calculator
// Multiplies the reload value by the clamped duty, then divides by the full
// scale through a multiply by its rounded-up reciprocal, taken 16 bits a cycle.
// ============================================================================
module mctt_duty #(
    parameter int COUNT_BITS      = mctt_pkg::COUNT_BITS_DEF,
    parameter int DUTY_FULL_SCALE = mctt_pkg::DUTY_FS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_reload,
    input  logic [15:0]           i_duty,
    output logic                  o_done,
    output logic [COUNT_BITS-1:0] o_quot
);

    localparam int PW  = COUNT_BITS + 16;
    localparam int LG  = $clog2(DUTY_FULL_SCALE);
    localparam int SH  = PW + LG;
    localparam int NCH = (PW + 2 + 15) / 16;
    localparam int MW  = 16 * NCH;
    localparam int AW  = PW + MW;
    localparam int CW  = $clog2(NCH + 1);
    localparam logic [15:0] FS = 16'(DUTY_FULL_SCALE);
    // Rounded up, the reciprocal gives the exact quotient for every product below 2**PW.
    localparam logic [127:0] RECIP_FULL =
        ((128'd1 << SH) + 128'(DUTY_FULL_SCALE) - 128'd1) / 128'(DUTY_FULL_SCALE);
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

    logic [15:0]    duty_sat;
    logic [PW-1:0]  prod;
    logic [PW+15:0] part;

    logic [PW-1:0]  r_x;
    logic [MW-1:0]  r_m;
    logic [AW-1:0]  r_acc;
    logic [CW-1:0]  r_cnt;
    logic           r_done;

    assign duty_sat = (i_duty > FS) ? FS : i_duty;
    assign prod     = i_reload * duty_sat;
    assign part     = r_x * r_m[MW-1 -: 16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(NCH);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The reciprocal is consumed from its top chunk down, so the sum shifts up each step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= prod;
            r_m   <= RECIP;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_acc <= {r_acc[AW-17:0], 16'd0} + AW'(part);
            r_m   <= {r_m[MW-17:0], 16'd0};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc[SH +: COUNT_BITS];

endmodule

[rtl/mctt_step.sv]
// ============================================================================
// mctt_step: channel update unit
// Computes the new entry of one channel for a tick visit or a command.
// ============================================================================
module mctt_step #(
    parameter int COUNT_BITS = mctt_pkg::COUNT_BITS_DEF
) (
    input  logic [2:0]              i_op,
    input  logic [1:0]              i_kind,
    input  logic [1:0]              i_phase,
    input  logic [COUNT_BITS-1:0]   i_reload,
    input  logic [COUNT_BITS-1:0]   i_count,
    input  logic [COUNT_BITS-1:0]   i_duty_ticks,
    input  logic [31:0]             i_target,
    input  logic [COUNT_BITS-1:0]   i_quot,
    output logic [1:0]              o_phase,
    output logic [COUNT_BITS-1:0]   o_reload,
    output logic [COUNT_BITS-1:0]   o_count,
    output logic [COUNT_BITS-1:0]   o_duty_ticks,
    output mctt_pkg::t_step_flags   o_flags,
    output logic [31:0]             o_remaining,
    output logic [31:0]             o_elapsed
);

    import mctt_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] cnt_dec;
    logic [31:0]           tgt_hi;
    logic [COUNT_BITS-1:0] tgt_sat;

    assign cnt_dec = i_count - COUNT_BITS'(1);
    assign tgt_hi  = i_target >> COUNT_BITS;
    assign tgt_sat = (tgt_hi != 32'd0) ? CNT_MAX : i_target[COUNT_BITS-1:0];

    always_comb begin
        o_phase      = i_phase;
        o_reload     = i_reload;
        o_count      = i_count;
        o_duty_ticks = i_duty_ticks;
        o_flags      = '0;
        o_remaining  = 32'd0;
        o_elapsed    = 32'd0;
        case (i_op)
            MODE_TICK: begin
                if (i_count != '0) begin
                    o_flags.wr = 1'b1;
                    o_count    = cnt_dec;
                    case (i_kind)
                        KIND_ONCE: begin
                            if (cnt_dec == '0) begin
                                o_phase           = PHASE_STOP;
                                o_flags.event_hit = 1'b1;
                            end
                        end
                        KIND_REPEAT: begin
                            if (cnt_dec == '0) begin
                                o_count           = i_reload;
                                o_flags.event_hit = 1'b1;
                            end
                        end
                        default: begin
                            if (cnt_dec == '0) begin
                                o_count = i_reload;
                            end
                            // With full duty the output stays high and only reloads.
                            if (i_duty_ticks != i_reload) begin
                                if (cnt_dec == '0) begin
                                    o_flags.pwm_wr  = 1'b1;
                                    o_flags.pwm_val = 1'b0;
                                end else if (cnt_dec == i_duty_ticks) begin
                                    o_flags.pwm_wr  = 1'b1;
                                    o_flags.pwm_val = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            MODE_START: begin
                if (i_target == 32'd0) begin
                    o_flags.bad_arg = 1'b1;
                end else begin
                    o_flags.wr = 1'b1;
                    if (i_phase == PHASE_STOP) begin
                        o_phase = PHASE_RUN;
                    end
                    o_reload = tgt_sat;
                    o_count  = tgt_sat;
                    if (i_kind == KIND_PWM) begin
                        o_duty_ticks = '0;
                    end
                end
            end
            MODE_STOP: begin
                o_flags.wr = 1'b1;
                o_count    = '0;
                o_phase    = PHASE_STOP;
                if (i_kind == KIND_PWM) begin
                    o_flags.pwm_wr  = 1'b1;
                    o_flags.pwm_val = 1'b0;
                end
            end
            MODE_DUTY: begin
                o_flags.wr   = 1'b1;
                o_duty_ticks = i_quot;
                if (i_kind == KIND_PWM && i_quot == i_reload) begin
                    o_flags.pwm_wr  = 1'b1;
                    o_flags.pwm_val = 1'b1;
                end
            end
            MODE_REMOVE: begin
                o_flags.wr = 1'b1;
                o_phase    = PHASE_REMOVE;
            end
            MODE_QUERY: begin
                if (i_phase == PHASE_RUN) begin
                    o_remaining = 32'(i_count);
                    o_elapsed   = 32'(i_reload - i_count);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/multi_channel_tick_timer_pwm.sv]
// ============================================================================
// multi_channel_tick_timer_pwm: bank of tick-driven timer / PWM channels
// Command-driven bank of down counters with one-shot, repeat and PWM kinds.
// ============================================================================
//
//  Port group     Direction  Handshake                  Payload
//  -------------  ---------  -------------------------  ------------------
//  command        in         start high while busy low  i_cmd  (t_cmd)
//  result         out        o_strobe, one cycle        o_res  (t_result)
//
// A tick walks every channel through the entry memory, a read state and then
// an update and write-back state per channel (S_RD, then S_EX). Allocate
// scans the used flags, one channel per cycle. Start, stop, remove and query
// pass through S_RD and S_EX; set duty then also waits in S_DUTY for the
// 16-bit steps of the reciprocal multiply. Commands rejected on mode, kind or
// channel never raise busy. The result strobe follows the last busy cycle.
// Reset frees all channels at once and clears their PWM levels. Results
// cannot be held off by the receiver.
//
module multi_channel_tick_timer_pwm #(
    parameter int CHANNELS        = mctt_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS      = mctt_pkg::COUNT_BITS_DEF,
    parameter int DUTY_FULL_SCALE = mctt_pkg::DUTY_FS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  mctt_pkg::t_cmd    i_cmd,
    output logic              busy,
    output logic              o_strobe,
    output mctt_pkg::t_result o_res
);

    import mctt_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W = 4 + 3 * COUNT_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_RD   = 5'b00100,
        S_EX   = 5'b01000,
        S_DUTY = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [CHANNELS-1:0]   r_used, n_used;
    logic [CHANNELS-1:0]   r_pwm, n_pwm;
    logic [7:0]            r_ev, n_ev;
    logic                  r_free_vld, n_free_vld;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic                  r_strobe, n_strobe;

    logic [1:0]            r_status;
    logic [2:0]            r_alloc;
    logic [7:0]            r_evout;
    logic [31:0]           r_rem;
    logic [31:0]           r_ela;

    logic [1:0]            fin_status;
    logic [2:0]            fin_alloc;
    logic [7:0]            fin_ev;
    logic [31:0]           fin_rem;
    logic [31:0]           fin_ela;

    logic                  mem_we;
    logic [ENT_W-1:0]      mem_wdata;
    logic [ENT_W-1:0]      mem_rdata;

    logic [1:0]            rd_kind;
    logic [1:0]            rd_phase;
    logic [COUNT_BITS-1:0] rd_reload;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS-1:0] rd_duty;

    logic [1:0]            st_phase;
    logic [COUNT_BITS-1:0] st_reload;
    logic [COUNT_BITS-1:0] st_count;
    logic [COUNT_BITS-1:0] st_duty;
    t_step_flags           st_flags;
    logic [31:0]           st_rem;
    logic [31:0]           st_ela;

    logic                  duty_go;
    logic                  duty_done;
    logic [COUNT_BITS-1:0] duty_quot;

    logic                  ch_ok;
    logic [IDX_W-1:0]      ch_idx;
    logic [63:0]           pwm_wide;

    assign rd_kind   = mem_rdata[ENT_W-1 -: 2];
    assign rd_phase  = mem_rdata[ENT_W-3 -: 2];
    assign rd_reload = mem_rdata[3*COUNT_BITS-1 -: COUNT_BITS];
    assign rd_count  = mem_rdata[2*COUNT_BITS-1 -: COUNT_BITS];
    assign rd_duty   = mem_rdata[COUNT_BITS-1:0];

    assign ch_ok  = (int'(i_cmd.channel) < CHANNELS);
    assign ch_idx = IDX_W'(i_cmd.channel);

    mctt_mem #(
        .DEPTH (CHANNELS),
        .WIDTH (ENT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    mctt_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_op         (r_cmd.mode),
        .i_kind       (rd_kind),
        .i_phase      (rd_phase),
        .i_reload     (rd_reload),
        .i_count      (rd_count),
        .i_duty_ticks (rd_duty),
        .i_target     (r_cmd.target),
        .i_quot       (duty_quot),
        .o_phase      (st_phase),
        .o_reload     (st_reload),
        .o_count      (st_count),
        .o_duty_ticks (st_duty),
        .o_flags      (st_flags),
        .o_remaining  (st_rem),
        .o_elapsed    (st_ela)
    );

    mctt_duty #(
        .COUNT_BITS      (COUNT_BITS),
        .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
    ) u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (duty_go),
        .i_reload (rd_reload),
        .i_duty   (r_cmd.duty),
        .o_done   (duty_done),
        .o_quot   (duty_quot)
    );

    // An allocated channel starts from a cleared entry.
    always_comb begin
        if (r_state == S_SCAN) begin
            mem_wdata = {r_cmd.kind, PHASE_STOP, {(3*COUNT_BITS){1'b0}}};
        end else begin
            mem_wdata = {rd_kind, st_phase, st_reload, st_count, st_duty};
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_used     = r_used;
        n_pwm      = r_pwm;
        n_ev       = r_ev;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_strobe   = 1'b0;
        fin_status = STATUS_OK;
        fin_alloc  = 3'd0;
        fin_ev     = 8'd0;
        fin_rem    = 32'd0;
        fin_ela    = 32'd0;
        mem_we     = 1'b0;
        duty_go    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd      = i_cmd;
                    n_idx      = '0;
                    n_ev       = 8'd0;
                    n_free_vld = 1'b0;
                    case (i_cmd.mode)
                        MODE_TICK: begin
                            n_state = S_RD;
                        end
                        MODE_ALLOC: begin
                            if (i_cmd.kind == KIND_ONCE || i_cmd.kind == KIND_REPEAT ||
                                i_cmd.kind == KIND_PWM) begin
                                n_state = S_SCAN;
                            end else begin
                                n_strobe   = 1'b1;
                                fin_status = STATUS_BAD_ARG;
                            end
                        end
                        MODE_START, MODE_STOP, MODE_DUTY, MODE_REMOVE, MODE_QUERY: begin
                            if (!ch_ok) begin
                                n_strobe   = 1'b1;
                                fin_status = STATUS_BAD_ARG;
                            end else if (!r_used[ch_idx]) begin
                                n_strobe   = 1'b1;
                                fin_status = STATUS_NOT_ALLOC;
                            end else begin
                                n_idx   = ch_idx;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_strobe   = 1'b1;
                            fin_status = STATUS_BAD_ARG;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_used[r_idx]) begin
                    mem_we        = 1'b1;
                    n_used[r_idx] = 1'b1;
                    n_pwm[r_idx]  = 1'b0;
                    n_strobe      = 1'b1;
                    n_state       = S_IDLE;
                    fin_alloc     = 3'(r_idx);
                end else if (r_idx == LAST_IDX) begin
                    n_strobe   = 1'b1;
                    n_state    = S_IDLE;
                    fin_status = STATUS_NO_FREE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                if (r_cmd.mode == MODE_TICK) begin
                    if (r_used[r_idx]) begin
                        if (rd_phase == PHASE_REMOVE) begin
                            if (!r_free_vld) begin
                                n_free_vld = 1'b1;
                                n_free_idx = r_idx;
                            end
                        end else begin
                            mem_we = st_flags.wr;
                            if (st_flags.event_hit) begin
                                n_ev = r_ev | (8'd1 << r_idx);
                            end
                            if (st_flags.pwm_wr) begin
                                n_pwm[r_idx] = st_flags.pwm_val;
                            end
                        end
                    end
                    if (r_idx == LAST_IDX) begin
                        // The lowest channel marked for removal is freed at the end.
                        if (n_free_vld) begin
                            n_used[n_free_idx] = 1'b0;
                            n_pwm[n_free_idx]  = 1'b0;
                        end
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                        fin_ev   = n_ev;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end else if (r_cmd.mode == MODE_DUTY) begin
                    duty_go = 1'b1;
                    n_state = S_DUTY;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (st_flags.bad_arg) begin
                        fin_status = STATUS_BAD_ARG;
                    end else begin
                        mem_we = st_flags.wr;
                        if (st_flags.pwm_wr) begin
                            n_pwm[r_idx] = st_flags.pwm_val;
                        end
                        fin_rem = st_rem;
                        fin_ela = st_ela;
                    end
                end
            end
            S_DUTY: begin
                if (duty_done) begin
                    mem_we = st_flags.wr;
                    if (st_flags.pwm_wr) begin
                        n_pwm[r_idx] = st_flags.pwm_val;
                    end
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_used     <= '0;
            r_pwm      <= '0;
            r_ev       <= 8'd0;
            r_free_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_used     <= n_used;
            r_pwm      <= n_pwm;
            r_ev       <= n_ev;
            r_free_vld <= n_free_vld;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_free_idx <= n_free_idx;
        if (n_strobe) begin
            r_status <= fin_status;
            r_alloc  <= fin_alloc;
            r_evout  <= fin_ev;
            r_rem    <= fin_rem;
            r_ela    <= fin_ela;
        end
    end

    assign pwm_wide = 64'(r_pwm);
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    always_comb begin
        o_res.status          = r_status;
        o_res.allocated_index = r_alloc;
        o_res.event_mask      = r_evout;
        o_res.pwm_levels      = pwm_wide[7:0];
        o_res.remaining       = r_rem;
        o_res.elapsed         = r_ela;
    end

endmodule

[rtl/mctt_chk.sv]
// ============================================================================
// mctt_chk: port-level checker for the tick timer / PWM bank
// Watches the command and result ports over time; bound to the top level.
// ============================================================================
module mctt_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input mctt_pkg::t_cmd    i_cmd,
    input logic              o_strobe,
    input mctt_pkg::t_result o_res
);

    import mctt_pkg::*;

    // Leaving the busy phase always delivers the transaction's result.
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result strobe");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.mode == MODE_TICK) |=> busy)
        else $error("tick transaction did not walk the channels");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start)))
        else $error("result strobe without a transaction");

    a_event_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.event_mask != 8'd0) |-> $past(busy))
        else $error("event mask outside a tick");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.status != STATUS_OK) |->
            (o_res.allocated_index == 3'd0 && o_res.event_mask == 8'd0 &&
             o_res.remaining == 32'd0 && o_res.elapsed == 32'd0))
        else $error("rejected transaction carries result data");

endmodule

bind multi_channel_tick_timer_pwm mctt_chk u_mctt_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
